@@ hdl/tpte_pkg.sv @@
// ---------------------------------------------------------------------------
// tpte_pkg: shared types and constants for the TWI packet transfer engine
// Request and status codes, item layouts and the engine state record.
// ---------------------------------------------------------------------------
`default_nettype none

package tpte_pkg;

  localparam int unsigned MAX_PAYLOAD = 15;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CNT_W       = 5;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] POS_SAT = '1;

  // request types
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SEND  = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;

  // bus commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // bus roles
  localparam logic [1:0] ROLE_IDLE   = 2'd0;
  localparam logic [1:0] ROLE_MASTER = 2'd1;
  localparam logic [1:0] ROLE_SLAVE  = 2'd2;

  // bus status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SR_SLA_ACK   = 8'h60;
  localparam logic [7:0] ST_SR_ARB_SLA   = 8'h68;
  localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
  localparam logic [7:0] ST_SR_STOP      = 8'hA0;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_BUS_ERROR    = 8'h00;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       payload_byte;
    logic [3:0]       msg_state;
    logic [3:0]       msg_len;
    logic [7:0]       status_code;
    logic [7:0]       rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] bus_cmd;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] bus_role;
    logic       send_pending;
    logic       send_rejected;
    logic       rx_done;
    logic [3:0] rx_state;
    logic [3:0] rx_len;
    logic       rx_overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       tx_header;
    logic [CNT_W-1:0] tx_count;
    logic [CNT_W-1:0] tx_pos;
    logic [1:0]       role;
    logic             pending;
    logic [7:0]       rx_header;
    logic [CNT_W-1:0] rx_pos;
  } eng_state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_wr_t;

endpackage

`default_nettype wire

@@ hdl/tpte_stream_if.sv @@
// ---------------------------------------------------------------------------
// tpte_stream_if: request and result channels
// Valid/ready channels carrying one request item or one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpte_in_if;
  import tpte_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpte_out_if;
  import tpte_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/twi_packet_transfer_engine.sv @@
// ---------------------------------------------------------------------------
// twi_packet_transfer_engine: two-wire bus packet engine
// Loads payload bytes, builds send headers and steps transmit and receive
// on bus status events, one result per request.
// ---------------------------------------------------------------------------
// Result path: a request transfer is captured in the input register, then
//   in the result register when that register is free.
// Throughput: one request per cycle; a stalled result holds the request in
//   the input register, and the input takes no new transfer until it moves.
// Reset: synchronous rst_n clears the pipeline valids, engine state and the
//   address register; the payload store is not cleared.
`default_nettype none

module twi_packet_transfer_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tpte_in_if.sink         in_ch,
  tpte_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import tpte_pkg::*;

  logic       in_valid_r;
  in_item_t   in_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  eng_state_t st_r;
  eng_state_t st_nxt;
  out_item_t  res;
  store_wr_t  wr;
  store_wr_t  buf_wr;
  logic [7:0] addr_r;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0] rd_data;
  logic       proc;

  // advance when the result register is free or drains this cycle
  assign proc         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || proc;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  tpte_core u_core (
    .item      (in_data_r),
    .st        (st_r),
    .addr_byte (addr_r),
    .rd_data   (rd_data),
    .rd_idx    (rd_idx),
    .wr        (wr),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // write the store only when the request actually advances
  always_comb begin
    buf_wr    = wr;
    buf_wr.en = wr.en && proc;
  end

  tpte_tx_buffer u_tx_buffer (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      addr_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        addr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
    if (proc) begin
      out_data_r <= res;
    end
  end

  // hold a waiting request while the result register is stalled
  property p_hold_in;
    @(posedge clk) disable iff (!rst_n)
      (in_valid_r && out_valid_r && !out_ch.ready) |=> in_valid_r;
  endproperty
  a_hold_in: assert property (p_hold_in) else $error("request dropped under stall");

  property p_done_idle;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.rx_done) |-> (out_data_r.bus_role == ROLE_IDLE);
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("rx_done with busy role");

  property p_reject_quiet;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.send_rejected) |-> (out_data_r.bus_cmd == CMD_NONE);
  endproperty
  a_reject_quiet: assert property (p_reject_quiet) else $error("rejected send issued command");

  property p_txbyte_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_data_r.tx_valid) |-> (out_data_r.tx_byte == 8'd0);
  endproperty
  a_txbyte_zero: assert property (p_txbyte_zero) else $error("tx_byte set without tx_valid");

endmodule

`default_nettype wire

@@ hdl/tpte_tx_buffer.sv @@
// ---------------------------------------------------------------------------
// tpte_tx_buffer: transmit payload store
// One write port from payload loads, one read port for the byte being sent.
// ---------------------------------------------------------------------------
`default_nettype none

module tpte_tx_buffer (
  input  wire logic                     clk,
  input  wire tpte_pkg::store_wr_t      wr,
  input  wire logic [tpte_pkg::IDX_W-1:0] rd_idx,
  output logic [7:0]                    rd_data
);
  import tpte_pkg::*;

  logic [7:0] mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx < MAX_IDX)) begin
      mem[wr.idx] <= wr.data;
    end
  end

  assign rd_data = (rd_idx < MAX_IDX) ? mem[rd_idx] : 8'd0;

endmodule

`default_nettype wire

@@ hdl/tpte_core.sv @@
// ---------------------------------------------------------------------------
// tpte_core: per-transfer decision logic
// Decodes one request against the engine state: next state, store write,
// and the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module tpte_core (
  input  wire tpte_pkg::in_item_t       item,
  input  wire tpte_pkg::eng_state_t     st,
  input  wire logic [7:0]               addr_byte,
  input  wire logic [7:0]               rd_data,
  output logic [tpte_pkg::IDX_W-1:0]    rd_idx,
  output tpte_pkg::store_wr_t           wr,
  output tpte_pkg::eng_state_t          st_nxt,
  output tpte_pkg::out_item_t           res
);
  import tpte_pkg::*;

  logic [CNT_W-1:0] pos_m1;
  logic [IDX_W-1:0] send_n;

  assign pos_m1 = st.tx_pos - CNT_W'(1);
  assign rd_idx = pos_m1[IDX_W-1:0];
  assign send_n = (item.msg_len < MAX_IDX) ? item.msg_len : MAX_IDX;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    wr.en   = 1'b0;
    wr.idx  = item.payload_index;
    wr.data = item.payload_byte;

    case (item.req_type)
      REQ_LOAD: begin
        wr.en = 1'b1;
      end
      REQ_SEND: begin
        if (st.role != ROLE_IDLE) begin
          res.send_rejected = 1'b1;
        end else begin
          st_nxt.tx_header = {item.msg_len, item.msg_state};
          st_nxt.tx_count  = {1'b0, send_n} + CNT_W'(1);
          st_nxt.tx_pos    = '0;
          st_nxt.pending   = 1'b1;
          res.bus_cmd      = CMD_START;
        end
      end
      REQ_EVENT: begin
        case (item.status_code)
          ST_START: begin
            st_nxt.pending = 1'b0;
            st_nxt.role    = ROLE_MASTER;
            res.tx_valid   = 1'b1;
            res.tx_byte    = addr_byte;
            res.bus_cmd    = CMD_ACK;
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            st_nxt.pending = 1'b0;
            if (st.tx_pos == '0) begin
              res.tx_valid  = 1'b1;
              res.tx_byte   = st.tx_header;
              st_nxt.tx_pos = CNT_W'(1);
              res.bus_cmd   = CMD_ACK;
            end else if (st.tx_pos < st.tx_count) begin
              res.tx_valid  = 1'b1;
              res.tx_byte   = (pos_m1 < MAX_CNT) ? rd_data : 8'd0;
              st_nxt.tx_pos = st.tx_pos + CNT_W'(1);
              res.bus_cmd   = CMD_ACK;
            end else begin
              // payload done: stop, and keep stopping on further ACKs
              st_nxt.tx_count = '0;
              st_nxt.role     = ROLE_IDLE;
              res.bus_cmd     = CMD_STOP;
            end
          end
          ST_ARB_LOST, ST_SR_SLA_ACK, ST_SR_ARB_SLA: begin
            st_nxt.role = ROLE_SLAVE;
            res.bus_cmd = CMD_ACK;
          end
          ST_SR_DATA_ACK, ST_SR_DATA_NACK: begin
            // receive payload is not observable; only header and overflow matter
            if (st.rx_pos == '0) begin
              st_nxt.rx_header = item.rx_byte;
            end else if (st.rx_pos > MAX_CNT) begin
              res.rx_overflow = 1'b1;
            end
            if (st.rx_pos != POS_SAT) begin
              st_nxt.rx_pos = st.rx_pos + CNT_W'(1);
            end
            res.bus_cmd = CMD_ACK;
          end
          ST_SR_STOP: begin
            res.rx_done   = 1'b1;
            res.rx_state  = st.rx_header[3:0];
            res.rx_len    = st.rx_header[7:4];
            st_nxt.role   = ROLE_IDLE;
            st_nxt.rx_pos = '0;
            res.bus_cmd   = CMD_ACK;
          end
          ST_MT_DATA_NACK, ST_MT_SLA_NACK, ST_BUS_ERROR: begin
            st_nxt.role    = ROLE_IDLE;
            st_nxt.pending = 1'b1;
            res.bus_cmd    = CMD_STOP;
          end
          default: begin
            res.bus_cmd = CMD_ACK;
          end
        endcase
      end
      default: begin
      end
    endcase

    res.bus_role     = st_nxt.role;
    res.send_pending = st_nxt.pending;
  end

endmodule

`default_nettype wire
